// ===== rtl/core/ddo_pkg.sv =====
// Shared types, constants and helper functions for the differential drive odometry block.
// Used by ddo_cordic, ddo_div and the top module; depends on nothing else.
`default_nettype none
package ddo_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [32:0] TURN_K = 33'd411774832;

    localparam logic [1:0] CFG_DIST_PER_TICK = 2'd0;
    localparam logic [1:0] CFG_HEAD_PER_TICK = 2'd1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_D,
        ST_MUL_HL,
        ST_MUL_HH,
        ST_BAM,
        ST_ROT_GO,
        ST_ROT_WAIT,
        ST_POS_LO,
        ST_POS_HI,
        ST_POS_SUM,
        ST_POS_ACC,
        ST_SPD_GO,
        ST_SPD_WAIT,
        ST_TRN_LO,
        ST_TRN_HI,
        ST_TRN_GO,
        ST_TRN_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [33:0] cos_v;
        logic signed [33:0] sin_v;
    } t_rot;

    typedef struct packed {
        logic        ovf;
        logic [31:0] quot;
    } t_div_res;

    function automatic logic [29:0] atan_bam(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            5'd24:   v = 30'h00000029;
            5'd25:   v = 30'h00000014;
            5'd26:   v = 30'h0000000A;
            5'd27:   v = 30'h00000005;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat_rate(input t_div_res r, input logic neg);
        logic [31:0] m;
        if (neg) begin
            m = (r.ovf || (r.quot > 32'h80000000)) ? 32'h80000000 : r.quot;
            return 32'h0 - m;
        end else begin
            return (r.ovf || r.quot[31]) ? 32'h7FFFFFFF : r.quot;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ddo_mul.sv =====
// Shared 33 by 33 bit unsigned multiplier with a registered product.
// Depends on nothing.
`default_nettype none
module ddo_mul (
    input  wire logic        i_clk,
    input  wire logic [32:0] i_a,
    input  wire logic [32:0] i_b,
    output logic      [65:0] o_p
);
    logic [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 66'(i_a) * 66'(i_b);
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ===== rtl/core/ddo_cordic.sv =====
// Iterative rotation unit: one CORDIC step per cycle gives cosine and sine in Q1.30.
// Depends on ddo_pkg for the arctangent table, step count and gain.
`default_nettype none
module ddo_cordic (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [31:0]   i_angle,
    output logic               o_done,
    output ddo_pkg::t_rot      o_rot
);
    import ddo_pkg::*;

    logic               r_busy, r_done, r_flip;
    logic [4:0]         r_idx;
    logic signed [33:0] r_x, r_y, r_z;
    logic [31:0]        quarter, folded;
    logic signed [33:0] dx, dy, at;

    assign quarter = i_angle + 32'h40000000;
    assign folded  = i_angle ^ {quarter[31], 31'b0};
    assign dx      = r_y >>> r_idx;
    assign dy      = r_x >>> r_idx;
    assign at      = $signed({4'b0, atan_bam(r_idx)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_idx == 5'(CORDIC_STEPS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= quarter[31];
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= $signed({{2{folded[31]}}, folded});
            r_idx  <= '0;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
            r_idx <= r_idx + 5'd1;
        end
    end

    assign o_done      = r_done;
    assign o_rot.cos_v = r_flip ? -r_x : r_x;
    assign o_rot.sin_v = r_flip ? -r_y : r_y;
endmodule
`default_nettype wire

// ===== rtl/core/ddo_div.sv =====
// Restoring divider giving floor(num / (den * 2^32)) one quotient bit per cycle, with overflow.
// Depends on ddo_pkg for the result struct.
`default_nettype none
module ddo_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [92:0]   i_num,
    input  wire logic [31:0]   i_den,
    output logic               o_done,
    output ddo_pkg::t_div_res  o_res
);
    import ddo_pkg::*;

    logic        r_busy, r_done, r_ovf;
    logic [4:0]  r_cnt;
    logic [63:0] r_rem;
    logic [31:0] r_low, r_den, r_quot;
    logic [64:0] trial, divisor;
    logic        fits, start_ovf;

    assign trial     = {r_rem, r_low[31]};
    assign divisor   = {1'b0, r_den, 32'b0};
    assign fits      = (trial >= divisor);
    assign start_ovf = ({3'b0, i_num[92:64]} >= i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !start_ovf;
                r_done <= start_ovf;
            end else if (r_busy && (r_cnt == 5'd31)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= start_ovf;
            r_rem <= {3'b0, i_num[92:32]};
            r_low <= i_num[31:0];
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? 64'(trial - divisor) : trial[63:0];
            r_quot <= {r_quot[30:0], fits};
            r_low  <= {r_low[30:0], 1'b0};
            r_cnt  <= r_cnt + 5'd1;
        end
    end

    assign o_done     = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quot = r_quot;
endmodule
`default_nettype wire

// ===== rtl/core/differential_drive_odometry_top.sv =====
// Differential drive wheel odometry: sequencer, state registers and result register.
// Depends on ddo_pkg, ddo_mul, ddo_cordic and ddo_div.
//
// Usage:
// An input word carries left and right encoder counts and a millisecond timestamp and is
// taken when i_valid and o_ready are high. o_ready is high only while the sequencer is
// idle. A word whose timestamp equals the stored one is dropped, and the first new word
// only records counts and time; both leave the sequencer idle and the block ready.
// Every later word yields one result word, and the next input word is taken only once
// the sequencer is back in idle: three multiplier passes and an add, a 28 step rotation,
// four passes for the position steps, two passes for the turn rate and two 32 step
// divisions for speed and turn rate, all on one shared multiplier, one rotation unit
// and one divider. A division whose quotient overflows ends at once.
// A result is held in an output register while o_valid is high and
// i_ready is low; the next input word is taken meanwhile, and the sequencer waits at
// its last step only if a new result is ready before the old one has left.
// Configuration words are taken at any time on the separate write channel, but must be
// written only while the block is idle.
// Synchronous reset clears position, heading, time, counts and both configuration
// registers, and empties the output register.
`default_nettype none
module differential_drive_odometry_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_left_count,
    input  wire logic signed [31:0] i_right_count,
    input  wire logic        [31:0] i_time_ms,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [47:0]      o_pos_x,
    output logic signed [47:0]      o_pos_y,
    output logic        [31:0]      o_heading,
    output logic signed [31:0]      o_speed,
    output logic signed [31:0]      o_turn_rate,
    output logic        [31:0]      o_elapsed_ms,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [47:0]        i_cfg_data
);
    import ddo_pkg::*;

    t_state r_state, n_state;

    logic               r_started, r_out_valid, r_axis;
    logic               r_sum_neg, r_diff_neg;
    logic [31:0]        r_last_time, r_last_left, r_last_right, r_heading, r_time_sum;
    logic [31:0]        r_dist, r_dt, r_speed, r_turn;
    logic [47:0]        r_hpt;
    logic signed [47:0] r_acc_x, r_acc_y;
    logic [32:0]        r_sm, r_dfm;
    logic [54:0]        r_dm;
    logic [63:0]        r_bam;
    logic [65:0]        r_lo;
    logic [56:0]        r_step;

    logic [32:0]        mul_a, mul_b;
    logic [65:0]        mul_p;
    logic               rot_start, rot_done, div_start, div_done;
    t_rot               rot;
    t_div_res           div_res;
    logic [92:0]        div_num;
    logic               in_take, out_free;

    logic [31:0]        dl, dr, dt_in, dth;
    logic signed [32:0] sum_s, diff_s;
    logic signed [33:0] trig, trig_mag;
    logic               pos_neg;
    logic [86:0]        pos_prod;
    logic signed [47:0] acc_sel;
    logic signed [58:0] acc_ext, acc_new;
    logic signed [47:0] acc_sat;
    logic [64:0]        dm_k;

    ddo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_angle (r_heading - dth),
        .o_done  (rot_done),
        .o_rot   (rot)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_dt),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    assign in_take  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    assign dl     = i_left_count - r_last_left;
    assign dr     = i_right_count - r_last_right;
    assign dt_in  = i_time_ms - r_last_time;
    assign sum_s  = $signed({dl[31], dl}) + $signed({dr[31], dr});
    assign diff_s = $signed({dr[31], dr}) - $signed({dl[31], dl});
    assign dth    = r_diff_neg ? (32'h0 - r_bam[31:0]) : r_bam[31:0];

    assign trig     = r_axis ? rot.sin_v : rot.cos_v;
    assign trig_mag = trig[33] ? -trig : trig;
    assign pos_neg  = r_sum_neg ^ trig[33];
    assign pos_prod = {mul_p[62:0], 24'b0} + 87'(r_lo);

    assign acc_sel = r_axis ? r_acc_y : r_acc_x;
    assign acc_ext = 59'(acc_sel);
    assign acc_new = pos_neg ? (acc_ext - $signed({2'b0, r_step}))
                             : (acc_ext + $signed({2'b0, r_step}));
    always_comb begin
        if (acc_new[58:47] == {12{acc_new[58]}}) begin
            acc_sat = acc_new[47:0];
        end else if (acc_new[58]) begin
            acc_sat = {1'b1, 47'b0};
        end else begin
            acc_sat = {1'b0, {47{1'b1}}};
        end
    end

    assign dm_k = {r_dm, 10'b0} - 65'({r_dm, 4'b0}) - 65'({r_dm, 3'b0});

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take && (i_time_ms != r_last_time) && r_started) begin
                    n_state = ST_MUL_D;
                end
            end
            ST_MUL_D:    n_state = ST_MUL_HL;
            ST_MUL_HL:   n_state = ST_MUL_HH;
            ST_MUL_HH:   n_state = ST_BAM;
            ST_BAM:      n_state = ST_ROT_GO;
            ST_ROT_GO:   n_state = ST_ROT_WAIT;
            ST_ROT_WAIT: begin
                if (rot_done) begin
                    n_state = ST_POS_LO;
                end
            end
            ST_POS_LO:   n_state = ST_POS_HI;
            ST_POS_HI:   n_state = ST_POS_SUM;
            ST_POS_SUM:  n_state = ST_POS_ACC;
            ST_POS_ACC:  n_state = r_axis ? ST_SPD_GO : ST_POS_LO;
            ST_SPD_GO:   n_state = ST_SPD_WAIT;
            ST_SPD_WAIT: begin
                if (div_done) begin
                    n_state = ST_TRN_LO;
                end
            end
            ST_TRN_LO:   n_state = ST_TRN_HI;
            ST_TRN_HI:   n_state = ST_TRN_GO;
            ST_TRN_GO:   n_state = ST_TRN_WAIT;
            ST_TRN_WAIT: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        rot_start = 1'b0;
        div_start = 1'b0;
        div_num   = {4'b0, dm_k, 24'b0};
        o_ready   = 1'b0;
        case (r_state)
            ST_IDLE:   o_ready = 1'b1;
            ST_MUL_D: begin
                mul_a = r_sm;
                mul_b = {1'b0, r_dist};
            end
            ST_MUL_HL: begin
                mul_a = r_dfm;
                mul_b = {1'b0, r_hpt[31:0]};
            end
            ST_MUL_HH: begin
                mul_a = r_dfm;
                mul_b = {17'b0, r_hpt[47:32]};
            end
            ST_ROT_GO: rot_start = 1'b1;
            ST_POS_LO: begin
                mul_a = {9'b0, r_dm[23:0]};
                mul_b = trig_mag[32:0];
            end
            ST_POS_HI: begin
                mul_a = {2'b0, r_dm[54:24]};
                mul_b = trig_mag[32:0];
            end
            ST_SPD_GO: div_start = 1'b1;
            ST_TRN_LO: begin
                mul_a = {1'b0, r_bam[31:0]};
                mul_b = TURN_K;
            end
            ST_TRN_HI: begin
                mul_a = {1'b0, r_bam[63:32]};
                mul_b = TURN_K;
            end
            ST_TRN_GO: begin
                div_start = 1'b1;
                div_num   = 93'({mul_p[60:0], 32'b0}) + 93'(r_lo);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_started    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_time  <= '0;
            r_last_left  <= '0;
            r_last_right <= '0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
            r_heading    <= '0;
            r_time_sum   <= '0;
            r_dist       <= '0;
            r_hpt        <= '0;
            r_axis       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DIST_PER_TICK: r_dist <= i_cfg_data[31:0];
                    CFG_HEAD_PER_TICK: r_hpt  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if ((r_state == ST_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_take && (i_time_ms != r_last_time)) begin
                        r_started    <= 1'b1;
                        r_last_time  <= i_time_ms;
                        r_last_left  <= i_left_count;
                        r_last_right <= i_right_count;
                        if (r_started) begin
                            r_time_sum <= r_time_sum + dt_in;
                        end
                    end
                    r_axis <= 1'b0;
                end
                ST_ROT_GO:  r_heading <= r_heading + dth;
                ST_POS_ACC: begin
                    if (r_axis) begin
                        r_acc_y <= acc_sat;
                    end else begin
                        r_acc_x <= acc_sat;
                    end
                    r_axis <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_dt       <= dt_in;
                r_sum_neg  <= sum_s[32];
                r_diff_neg <= diff_s[32];
                r_sm       <= sum_s[32] ? 33'(-sum_s) : 33'(sum_s);
                r_dfm      <= diff_s[32] ? 33'(-diff_s) : 33'(diff_s);
            end
            ST_MUL_HL:   r_dm  <= mul_p[63:9];
            ST_MUL_HH:   r_bam <= {16'b0, mul_p[63:16]};
            ST_BAM:      r_bam <= r_bam + {mul_p[47:0], 16'b0};
            ST_POS_HI:   r_lo  <= mul_p;
            ST_POS_SUM:  r_step <= pos_prod[86:30];
            ST_SPD_WAIT: begin
                if (div_done) begin
                    r_speed <= sat_rate(div_res, r_sum_neg);
                end
            end
            ST_TRN_HI:   r_lo  <= mul_p;
            ST_TRN_WAIT: begin
                if (div_done) begin
                    r_turn <= sat_rate(div_res, r_diff_neg);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    o_pos_x      <= r_acc_x;
                    o_pos_y      <= r_acc_y;
                    o_heading    <= r_heading;
                    o_speed      <= r_speed;
                    o_turn_rate  <= r_turn;
                    o_elapsed_ms <= r_time_sum;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_SPD_WAIT) || (r_state == ST_TRN_WAIT))
        else $error("divider finished outside a wait step");
    a_rot_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rot_done |-> (r_state == ST_ROT_WAIT))
        else $error("rotation finished outside its wait step");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) && out_free |=> o_valid && (r_state == ST_IDLE))
        else $error("result word not presented after the last step");
`endif
endmodule
`default_nettype wire
